[hw/rtl/alm_pkg.sv]
// Shared types and constants for the array-backed linked list manager.
package alm_pkg;

    localparam int KIND_W  = 3;
    localparam int POS_W   = 4;
    localparam int NAME_W  = 64;
    localparam int NUM_W   = 20;
    localparam int PAY_W   = 31;
    localparam int STAT_W  = 2;
    localparam int SLOT_W  = 4;
    localparam int COUNT_W = 5;
    localparam int LINK_W  = 5;

    localparam logic [LINK_W-1:0] END_MARK = 5'd31;

    localparam logic [KIND_W-1:0] KIND_ADD_FIRST = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ADD_AFTER = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ADD_LAST  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DEL_FIRST = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DEL_AFTER = 3'd4;
    localparam logic [KIND_W-1:0] KIND_DEL_LAST  = 3'd5;
    localparam logic [KIND_W-1:0] KIND_DEL_ALL   = 3'd6;
    localparam logic [KIND_W-1:0] KIND_UNUSED    = 3'd7;

    localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_BADPOS = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  position;
        logic [NAME_W-1:0] name_text;
        logic [NUM_W-1:0]  employee_number;
        logic [PAY_W-1:0]  base_pay;
    } op_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [SLOT_W-1:0]  slot;
        logic [COUNT_W-1:0] count;
    } result_t;

    typedef struct packed {
        logic              wr_en;
        logic [LINK_W-1:0] wr_addr;
        logic [LINK_W-1:0] wr_data;
        logic [LINK_W-1:0] rd_addr;
    } link_req_t;

    typedef struct packed {
        logic              wr_en;
        logic [LINK_W-1:0] addr;
        logic [NAME_W-1:0] name_text;
        logic [NUM_W-1:0]  employee_number;
        logic [PAY_W-1:0]  base_pay;
    } entry_wr_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_LINK_WAIT,
        ST_AFTER_WAIT,
        ST_WALK,
        ST_WRITE2
    } state_t;

endpackage

[hw/rtl/alm_link_ram.sv]
// Link table memory: one write port and one registered read port.
module alm_link_ram #(
    parameter int SLOTS = 16
) (
    input  logic                       clk,
    input  alm_pkg::link_req_t         req,
    output logic [alm_pkg::LINK_W-1:0] rdata
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [alm_pkg::LINK_W-1:0] mem [SLOTS];
    logic [alm_pkg::LINK_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr[IW-1:0]] <= req.wr_data;
        end
        rdata_reg <= mem[req.rd_addr[IW-1:0]];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/alm_entry_ram.sv]
// Entry data memories holding name, employee number and base pay per slot.
module alm_entry_ram #(
    parameter int SLOTS = 16
) (
    input  logic               clk,
    input  alm_pkg::entry_wr_t wr
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [alm_pkg::NAME_W-1:0] name_mem   [SLOTS];
    logic [alm_pkg::NUM_W-1:0]  number_mem [SLOTS];
    logic [alm_pkg::PAY_W-1:0]  pay_mem    [SLOTS];

    always_ff @(posedge clk)
    begin
        if (wr.wr_en)
        begin
            name_mem[wr.addr[IW-1:0]]   <= wr.name_text;
            number_mem[wr.addr[IW-1:0]] <= wr.employee_number;
            pay_mem[wr.addr[IW-1:0]]    <= wr.base_pay;
        end
    end

endmodule

[hw/rtl/alm_ctrl.sv]
// Operation sequencer: slot occupancy, head, count and link table accesses.
module alm_ctrl #(
    parameter int SLOTS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  alm_pkg::op_t               op,
    output logic                       busy,
    output logic                       done,
    output alm_pkg::result_t           result,
    output alm_pkg::link_req_t         link_req,
    input  logic [alm_pkg::LINK_W-1:0] link_rdata,
    output alm_pkg::entry_wr_t         entry_wr
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [alm_pkg::COUNT_W-1:0] SLOTS_C = alm_pkg::COUNT_W'(SLOTS);
    localparam logic [alm_pkg::LINK_W-1:0]  SLOTS_L = alm_pkg::LINK_W'(SLOTS);

    alm_pkg::state_t               state_reg, state_next;
    alm_pkg::op_t                  op_reg;
    logic [SLOTS-1:0]              used_reg, used_next;
    logic [alm_pkg::LINK_W-1:0]    head_reg, head_next;
    logic [alm_pkg::COUNT_W-1:0]   count_reg, count_next;
    logic [alm_pkg::LINK_W-1:0]    cur_reg, cur_next;
    logic [alm_pkg::LINK_W-1:0]    prev_reg, prev_next;
    logic [alm_pkg::LINK_W-1:0]    slot_reg, slot_next;
    logic [alm_pkg::LINK_W-1:0]    tgt_reg, tgt_next;
    logic                          done_reg, done_next;
    alm_pkg::result_t              result_reg, result_next;

    logic [SLOTS-1:0]              free_vec;
    logic [SLOTS-1:0]              free_iso;
    logic [alm_pkg::LINK_W-1:0]    free_slot;
    logic [alm_pkg::LINK_W-1:0]    pos_ext;
    logic                          full;
    logic                          empty;
    logic                          fin;
    logic [alm_pkg::STAT_W-1:0]    fin_status;
    logic [alm_pkg::LINK_W-1:0]    fin_slot;

    function automatic logic slot_valid(input logic [alm_pkg::LINK_W-1:0] s,
                                        input logic [SLOTS-1:0] used);
        return (s < SLOTS_L) && used[s[IW-1:0]];
    endfunction

    // Lowest free slot: isolate the lowest set bit of the free vector, then
    // OR together the indexes of the (single) set bit.
    always_comb
    begin
        free_vec  = ~used_reg;
        free_iso  = free_vec & (~free_vec + 1'b1);
        free_slot = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (free_iso[i])
            begin
                free_slot = free_slot | alm_pkg::LINK_W'(i);
            end
        end
    end

    assign pos_ext = alm_pkg::LINK_W'(op_reg.position);
    assign full    = (count_reg >= SLOTS_C);
    assign empty   = (head_reg == alm_pkg::END_MARK);
    assign busy    = (state_reg != alm_pkg::ST_IDLE);
    assign done    = done_reg;
    assign result  = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= alm_pkg::ST_IDLE;
            used_reg  <= '0;
            head_reg  <= alm_pkg::END_MARK;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == alm_pkg::ST_IDLE && start)
        begin
            op_reg <= op;
        end
        cur_reg    <= cur_next;
        prev_reg   <= prev_next;
        slot_reg   <= slot_next;
        tgt_reg    <= tgt_next;
        result_reg <= result_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        used_next   = used_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        cur_next    = cur_reg;
        prev_next   = prev_reg;
        slot_next   = slot_reg;
        tgt_next    = tgt_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        fin         = 1'b0;
        fin_status  = alm_pkg::STAT_OK;
        fin_slot    = '0;

        link_req.wr_en   = 1'b0;
        link_req.wr_addr = free_slot;
        link_req.wr_data = alm_pkg::END_MARK;
        link_req.rd_addr = head_reg;

        entry_wr.wr_en           = 1'b0;
        entry_wr.addr            = free_slot;
        entry_wr.name_text       = op_reg.name_text;
        entry_wr.employee_number = op_reg.employee_number;
        entry_wr.base_pay        = op_reg.base_pay;

        unique case (state_reg)
            alm_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = alm_pkg::ST_DISPATCH;
                end
            end

            alm_pkg::ST_DISPATCH:
            begin
                // Add last on an empty list takes the add first path.
                if (op_reg.kind == alm_pkg::KIND_ADD_FIRST ||
                    (op_reg.kind == alm_pkg::KIND_ADD_LAST && empty))
                begin
                    if (full)
                    begin
                        fin        = 1'b1;
                        fin_status = alm_pkg::STAT_FULL;
                    end
                    else
                    begin
                        link_req.wr_en   = 1'b1;
                        link_req.wr_data = head_reg;
                        entry_wr.wr_en   = 1'b1;
                        used_next[free_slot[IW-1:0]] = 1'b1;
                        count_next = count_reg + 1'b1;
                        head_next  = free_slot;
                        fin        = 1'b1;
                        fin_slot   = free_slot;
                    end
                end
                else if (op_reg.kind == alm_pkg::KIND_ADD_AFTER)
                begin
                    if (full)
                    begin
                        fin        = 1'b1;
                        fin_status = alm_pkg::STAT_FULL;
                    end
                    else if (!slot_valid(pos_ext, used_reg))
                    begin
                        fin        = 1'b1;
                        fin_status = alm_pkg::STAT_BADPOS;
                    end
                    else
                    begin
                        link_req.rd_addr = pos_ext;
                        state_next       = alm_pkg::ST_LINK_WAIT;
                    end
                end
                else if (op_reg.kind == alm_pkg::KIND_ADD_LAST)
                begin
                    if (full)
                    begin
                        fin        = 1'b1;
                        fin_status = alm_pkg::STAT_FULL;
                    end
                    else
                    begin
                        cur_next   = head_reg;
                        prev_next  = alm_pkg::END_MARK;
                        state_next = alm_pkg::ST_WALK;
                    end
                end
                else if (op_reg.kind == alm_pkg::KIND_DEL_FIRST)
                begin
                    if (empty)
                    begin
                        fin        = 1'b1;
                        fin_status = alm_pkg::STAT_EMPTY;
                    end
                    else
                    begin
                        state_next = alm_pkg::ST_LINK_WAIT;
                    end
                end
                else if (op_reg.kind == alm_pkg::KIND_DEL_AFTER)
                begin
                    if (!slot_valid(pos_ext, used_reg))
                    begin
                        fin        = 1'b1;
                        fin_status = alm_pkg::STAT_BADPOS;
                    end
                    else
                    begin
                        link_req.rd_addr = pos_ext;
                        state_next       = alm_pkg::ST_LINK_WAIT;
                    end
                end
                else if (op_reg.kind == alm_pkg::KIND_DEL_LAST)
                begin
                    if (empty)
                    begin
                        fin        = 1'b1;
                        fin_status = alm_pkg::STAT_EMPTY;
                    end
                    else
                    begin
                        cur_next   = head_reg;
                        prev_next  = alm_pkg::END_MARK;
                        state_next = alm_pkg::ST_WALK;
                    end
                end
                else if (op_reg.kind == alm_pkg::KIND_DEL_ALL)
                begin
                    used_next  = '0;
                    head_next  = alm_pkg::END_MARK;
                    count_next = '0;
                    fin        = 1'b1;
                end
                else
                begin
                    fin = 1'b1;
                end
            end

            alm_pkg::ST_LINK_WAIT:
            begin
                // link_rdata holds the successor of the position or the head.
                if (op_reg.kind == alm_pkg::KIND_ADD_AFTER)
                begin
                    link_req.wr_en   = 1'b1;
                    link_req.wr_data = link_rdata;
                    entry_wr.wr_en   = 1'b1;
                    used_next[free_slot[IW-1:0]] = 1'b1;
                    count_next = count_reg + 1'b1;
                    slot_next  = free_slot;
                    tgt_next   = pos_ext;
                    state_next = alm_pkg::ST_WRITE2;
                end
                else if (op_reg.kind == alm_pkg::KIND_DEL_FIRST)
                begin
                    // A freed slot's link is never read before it is refilled.
                    head_next = link_rdata;
                    used_next[head_reg[IW-1:0]] = 1'b0;
                    count_next = count_reg - 1'b1;
                    fin        = 1'b1;
                    fin_slot   = head_reg;
                end
                else
                begin
                    if (!slot_valid(link_rdata, used_reg))
                    begin
                        fin        = 1'b1;
                        fin_status = alm_pkg::STAT_EMPTY;
                    end
                    else
                    begin
                        slot_next        = link_rdata;
                        link_req.rd_addr = link_rdata;
                        state_next       = alm_pkg::ST_AFTER_WAIT;
                    end
                end
            end

            alm_pkg::ST_AFTER_WAIT:
            begin
                // Unlink the victim: the position takes over its successor.
                link_req.wr_en   = 1'b1;
                link_req.wr_addr = pos_ext;
                link_req.wr_data = link_rdata;
                used_next[slot_reg[IW-1:0]] = 1'b0;
                count_next = count_reg - 1'b1;
                fin        = 1'b1;
                fin_slot   = slot_reg;
            end

            alm_pkg::ST_WALK:
            begin
                link_req.rd_addr = link_rdata;
                if (slot_valid(link_rdata, used_reg))
                begin
                    prev_next = cur_reg;
                    cur_next  = link_rdata;
                end
                else if (op_reg.kind == alm_pkg::KIND_ADD_LAST)
                begin
                    link_req.wr_en   = 1'b1;
                    link_req.wr_data = alm_pkg::END_MARK;
                    entry_wr.wr_en   = 1'b1;
                    used_next[free_slot[IW-1:0]] = 1'b1;
                    count_next = count_reg + 1'b1;
                    slot_next  = free_slot;
                    tgt_next   = cur_reg;
                    state_next = alm_pkg::ST_WRITE2;
                end
                else
                begin
                    if (prev_reg == alm_pkg::END_MARK)
                    begin
                        head_next = alm_pkg::END_MARK;
                    end
                    else
                    begin
                        link_req.wr_en   = 1'b1;
                        link_req.wr_addr = prev_reg;
                        link_req.wr_data = alm_pkg::END_MARK;
                    end
                    used_next[cur_reg[IW-1:0]] = 1'b0;
                    count_next = count_reg - 1'b1;
                    fin        = 1'b1;
                    fin_slot   = cur_reg;
                end
            end

            alm_pkg::ST_WRITE2:
            begin
                link_req.wr_en   = 1'b1;
                link_req.wr_addr = tgt_reg;
                link_req.wr_data = slot_reg;
                fin              = 1'b1;
                fin_slot         = slot_reg;
            end

            default:
            begin
                state_next = alm_pkg::ST_IDLE;
            end
        endcase

        if (fin)
        begin
            state_next         = alm_pkg::ST_IDLE;
            done_next          = 1'b1;
            result_next.status = fin_status;
            result_next.slot   = fin_slot[alm_pkg::SLOT_W-1:0];
            result_next.count  = count_next;
        end
    end

endmodule

[hw/rtl/array_linked_list_manager.sv]
// Top level of the array-backed singly linked list manager.
//
// Usage: present an operation on op and raise start; the item is taken at a
// rising edge where start is high and busy is low. Each item produces exactly
// one result on result, marked by done for a single cycle. The receiver
// cannot stall, so the result must be captured in that cycle.
// Add first, clear all and the unused kind finish in the dispatch state;
// delete first also waits for the head's link read; add after and delete
// after read the position's link and then pass through a second state; add
// last and delete last walk the link table one entry per cycle through its
// single registered read port. Add last on an empty list runs as add first.
// A new item can be accepted in the same cycle that done is high. Failed
// checks (full, empty, bad position) finish in the dispatch state, except
// delete after at the tail, which needs the link read.
// Reset frees every slot, empties the list and clears the count; the link
// and entry memories are not cleared because a slot is always written before
// its link is read.
module array_linked_list_manager #(
    parameter int SLOTS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  alm_pkg::op_t     op,
    output logic             busy,
    output logic             done,
    output alm_pkg::result_t result
);

    alm_pkg::link_req_t         link_req;
    logic [alm_pkg::LINK_W-1:0] link_rdata;
    alm_pkg::entry_wr_t         entry_wr;

    // Sequencer: holds occupancy, head and count, and drives both memories.
    alm_ctrl #(
        .SLOTS(SLOTS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .op         (op),
        .busy       (busy),
        .done       (done),
        .result     (result),
        .link_req   (link_req),
        .link_rdata (link_rdata),
        .entry_wr   (entry_wr)
    );

    // Link table: next-slot pointer for every slot.
    alm_link_ram #(
        .SLOTS(SLOTS)
    ) u_link_ram (
        .clk   (clk),
        .req   (link_req),
        .rdata (link_rdata)
    );

    // Entry payload storage, written when a slot is filled.
    alm_entry_ram #(
        .SLOTS(SLOTS)
    ) u_entry_ram (
        .clk (clk),
        .wr  (entry_wr)
    );

    // An accepted item always keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after accepting an item");

    // A result strobe follows a cycle of work.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without preceding work");

    // A failed operation reports slot zero.
    a_fail_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != alm_pkg::STAT_OK) |-> (result.slot == '0))
        else $error("failed operation reports a nonzero slot");

    // The count never exceeds the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.count <= alm_pkg::COUNT_W'(SLOTS)))
        else $error("entry count above capacity");

endmodule
